// ----- rtl/core/token_classifier_unit_assert.svh -----
// Assertion macros used by the checker file
`ifndef TOKEN_CLASSIFIER_UNIT_ASSERT_SVH
`define TOKEN_CLASSIFIER_UNIT_ASSERT_SVH

// same-cycle implication
`define TCU_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("token classifier check failed");

// next-cycle implication
`define TCU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("token classifier check failed");

`endif

// ----- rtl/core/tcu_pkg.sv -----
package tcu_pkg;

   localparam int DefaultMaxTokenLength = 255;
   localparam int DefaultQueueDepth = 4;
   localparam int KwDepth = 5;

   localparam logic [2:0] ClsIdent = 3'd0;
   localparam logic [2:0] ClsKey = 3'd1;
   localparam logic [2:0] ClsDec = 3'd2;
   localparam logic [2:0] ClsOct = 3'd3;
   localparam logic [2:0] ClsHex = 3'd4;
   localparam logic [2:0] ClsDelim = 3'd5;
   localparam logic [2:0] ClsErr = 3'd6;
   localparam logic [2:0] ClsEnd = 3'd7;

   typedef struct packed {
      logic [7:0] ch;
      logic end_of_input;
   } req_type;

   typedef struct packed {
      logic [2:0] token_class;
      logic [7:0] token_length;
      logic last;
   } rsp_type;

   // up to two results caused by one request
   typedef struct packed {
      logic two;
      rsp_type r0;
      rsp_type r1;
   } pair_type;

   function automatic logic is_alpha(input logic [7:0] c);
      is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = (c >= "0" && c <= "9");
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      is_hex = is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic is_sep(input logic [7:0] c);
      is_sep = (c < 8'd33);
   endfunction

endpackage

// ----- rtl/core/tcu_front.sv -----
module tcu_front import tcu_pkg::*; #(
   parameter int MAX_TOKEN_LENGTH = DefaultMaxTokenLength
) (
   input  logic clock,
   input  logic reset,
   input  logic accept,
   input  req_type req,
   output logic wr_valid,
   output pair_type wr_data
);

   localparam logic [7:0] LenLimit =
      8'(MAX_TOKEN_LENGTH < 255 ? MAX_TOKEN_LENGTH : 255);

   typedef enum logic [2:0] {
      ModeIdle, ModeIdent, ModeZero, ModeZeroX, ModeHex, ModeOct, ModeDec
   } mode_type;

   typedef struct packed {
      logic valid;
      logic [2:0] cls;
      logic [7:0] len;
   } emit_type;

   mode_type mode_ff, mode_in;
   logic [7:0] len_ff, len_in;
   logic ended_ff, ended_in;
   logic [7:0] kw_ff [KwDepth];

   logic kw_we;
   logic [2:0] kw_idx;
   logic [7:0] grown;
   logic keyword;
   emit_type flush_em, p_em, q_em;
   logic [7:0] c;

   assign c = req.ch;
   assign grown = (len_ff < LenLimit) ? len_ff + 8'd1 : len_ff;

   always_comb begin
      keyword = 1'b0;
      if (len_ff == 8'd2) begin
         keyword = (kw_ff[0] == "d" && kw_ff[1] == "o") ||
                   (kw_ff[0] == "i" && kw_ff[1] == "f");
      end else if (len_ff == 8'd4) begin
         keyword = (kw_ff[0] == "e" && kw_ff[1] == "l" && kw_ff[2] == "s" &&
                    kw_ff[3] == "e") ||
                   (kw_ff[0] == "t" && kw_ff[1] == "h" && kw_ff[2] == "e" &&
                    kw_ff[3] == "n");
      end else if (len_ff == 8'd5) begin
         keyword = kw_ff[0] == "w" && kw_ff[1] == "h" && kw_ff[2] == "e" &&
                   kw_ff[3] == "r" && kw_ff[4] == "e";
      end
   end

   // token pending in the current mode
   always_comb begin
      flush_em = '{valid: 1'b1, cls: ClsDec, len: len_ff};
      unique case (mode_ff)
         ModeIdent: flush_em.cls = keyword ? ClsKey : ClsIdent;
         ModeZero, ModeDec: flush_em.cls = ClsDec;
         ModeZeroX: flush_em.cls = ClsErr;
         ModeHex: flush_em.cls = ClsHex;
         ModeOct: flush_em.cls = ClsOct;
         default: flush_em.valid = 1'b0;
      endcase
   end

   always_comb begin
      logic restart;
      restart = 1'b0;
      mode_in = mode_ff;
      len_in = len_ff;
      ended_in = ended_ff;
      kw_we = 1'b0;
      kw_idx = 3'd0;
      p_em = '0;
      q_em = '0;
      if (ended_ff) begin
         q_em = '{valid: 1'b1, cls: ClsEnd, len: 8'd0};
      end else if (req.end_of_input) begin
         p_em = flush_em;
         q_em = '{valid: 1'b1, cls: ClsEnd, len: 8'd0};
         ended_in = 1'b1;
         mode_in = ModeIdle;
         len_in = 8'd0;
      end else begin
         unique case (mode_ff)
            ModeIdent: begin
               if (is_alpha(c) || is_digit(c)) begin
                  kw_we = (len_ff < 8'(KwDepth));
                  kw_idx = len_ff[2:0];
                  len_in = grown;
               end else begin
                  p_em = flush_em;
                  restart = 1'b1;
               end
            end
            ModeZero: begin
               if (c == "x" || c == "X") begin
                  len_in = grown;
                  mode_in = ModeZeroX;
               end else if (c >= "1" && c <= "7") begin
                  len_in = grown;
                  mode_in = ModeOct;
               end else if (c == "0" || c == "8" || c == "9") begin
                  p_em = '{valid: 1'b1, cls: ClsErr, len: grown};
                  mode_in = ModeIdle;
                  len_in = 8'd0;
               end else begin
                  p_em = flush_em;
                  restart = 1'b1;
               end
            end
            ModeZeroX: begin
               if (is_hex(c)) begin
                  len_in = grown;
                  mode_in = ModeHex;
               end else if (is_sep(c)) begin
                  p_em = flush_em;
                  mode_in = ModeIdle;
                  len_in = 8'd0;
               end else begin
                  p_em = '{valid: 1'b1, cls: ClsErr, len: grown};
                  mode_in = ModeIdle;
                  len_in = 8'd0;
               end
            end
            ModeHex: begin
               if (is_hex(c)) len_in = grown;
               else begin
                  p_em = flush_em;
                  restart = 1'b1;
               end
            end
            ModeOct: begin
               if (c >= "0" && c <= "7") len_in = grown;
               else begin
                  p_em = flush_em;
                  restart = 1'b1;
               end
            end
            ModeDec: begin
               if (is_digit(c)) len_in = grown;
               else begin
                  p_em = flush_em;
                  restart = 1'b1;
               end
            end
            default: restart = 1'b1;
         endcase
         // this character may open the next token
         if (restart) begin
            mode_in = ModeIdle;
            len_in = 8'd0;
            if (is_sep(c)) begin
               mode_in = ModeIdle;
            end else if (is_alpha(c)) begin
               kw_we = 1'b1;
               kw_idx = 3'd0;
               len_in = 8'd1;
               mode_in = ModeIdent;
            end else if (c == "0") begin
               len_in = 8'd1;
               mode_in = ModeZero;
            end else if (is_digit(c)) begin
               len_in = 8'd1;
               mode_in = ModeDec;
            end else begin
               q_em = '{valid: 1'b1, cls: ClsDelim, len: 8'd1};
            end
         end
      end
   end

   always_comb begin
      emit_type first;
      first = p_em.valid ? p_em : q_em;
      wr_valid = accept && (p_em.valid || q_em.valid);
      wr_data.two = p_em.valid && q_em.valid;
      wr_data.r0 = '{token_class: first.cls, token_length: first.len,
                     last: !(p_em.valid && q_em.valid)};
      wr_data.r1 = '{token_class: q_em.cls, token_length: q_em.len, last: 1'b1};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ModeIdle;
         len_ff <= 8'd0;
         ended_ff <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         len_ff <= len_in;
         ended_ff <= ended_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && kw_we) kw_ff[kw_idx] <= c;
   end

endmodule

// ----- rtl/core/tcu_fifo.sv -----
module tcu_fifo import tcu_pkg::*; #(
   parameter int DEPTH = DefaultQueueDepth
) (
   input  logic clock,
   input  logic reset,
   input  logic wr_valid,
   input  pair_type wr_data,
   output logic full,
   input  logic rd_pop,
   output logic empty,
   output pair_type rd_data
);

   localparam int AddrW = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int CountW = $clog2(DEPTH + 1);
   localparam logic [AddrW-1:0] LastAddr = AddrW'(DEPTH - 1);

   pair_type store_ff [DEPTH];
   logic [AddrW-1:0] wptr_ff, rptr_ff;
   logic [CountW-1:0] count_ff;
   logic do_wr, do_rd;

   assign full = (count_ff == CountW'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_wr = wr_valid && !full;
   assign do_rd = rd_pop && !empty;
   assign rd_data = store_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_wr) wptr_ff <= (wptr_ff == LastAddr) ? '0 : wptr_ff + 1'b1;
         if (do_rd) rptr_ff <= (rptr_ff == LastAddr) ? '0 : rptr_ff + 1'b1;
         if (do_wr && !do_rd) count_ff <= count_ff + 1'b1;
         else if (do_rd && !do_wr) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) store_ff[wptr_ff] <= wr_data;
   end

endmodule

// ----- rtl/core/tcu_back.sv -----
module tcu_back import tcu_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic q_empty,
   input  pair_type q_data,
   output logic q_pop,
   output logic rsp_empty,
   input  logic rsp_pop,
   output rsp_type rsp_data
);

   pair_type cur_ff;
   logic valid_ff, sel_ff;
   logic done, advance;

   // current entry finished once its final result is popped
   assign done = valid_ff && rsp_pop && (sel_ff || !cur_ff.two);
   assign advance = !valid_ff || done;
   assign q_pop = advance && !q_empty;
   assign rsp_empty = !valid_ff;
   assign rsp_data = sel_ff ? cur_ff.r1 : cur_ff.r0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff <= 1'b0;
      end else begin
         priority if (advance) begin
            valid_ff <= !q_empty;
            sel_ff <= 1'b0;
         end else if (rsp_pop) begin
            sel_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) cur_ff <= q_data;
   end

endmodule

// ----- rtl/core/token_classifier_unit.sv -----
// Token classifier: one character per request in, up to two tokens out.
// Input channel: req_push / req_full, payload req_data (ch, end_of_input).
// A request is taken when req_push is high and req_full is low.
// Result channel: rsp_empty / rsp_pop, payload rsp_data (token_class,
// token_length, last); the oldest token waits on rsp_data while rsp_empty is low.
// A character causes zero, one or two tokens; last marks its final one.
// Throughput: one character per cycle while req_full is low, set by the scanner;
// tokens leave at one per cycle via the result register while rsp_pop is high.
// A token reaches rsp_data via a queue entry and then the result register.
// The scanner writes up to two tokens per entry to a QUEUE_DEPTH-entry queue;
// the result stage unpacks an entry over one or two pops.
// When the receiver stalls the queue fills and req_full rises; nothing is lost.
// Reset (synchronous) empties the queue, drops any pending token and clears the
// end-of-input flag; after end of input every request yields one end token.
module token_classifier_unit import tcu_pkg::*; #(
   parameter int MAX_TOKEN_LENGTH = DefaultMaxTokenLength,
   parameter int QUEUE_DEPTH = DefaultQueueDepth
) (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  req_type req_data,
   output logic rsp_empty,
   input  logic rsp_pop,
   output rsp_type rsp_data
);

   logic accept;
   logic wr_valid;
   pair_type wr_data;
   logic q_pop, q_empty;
   pair_type q_data;

   assign accept = req_push && !req_full;

   tcu_front #(.MAX_TOKEN_LENGTH(MAX_TOKEN_LENGTH)) u_front (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .req(req_data),
      .wr_valid(wr_valid),
      .wr_data(wr_data)
   );

   tcu_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock(clock),
      .reset(reset),
      .wr_valid(wr_valid),
      .wr_data(wr_data),
      .full(req_full),
      .rd_pop(q_pop),
      .empty(q_empty),
      .rd_data(q_data)
   );

   tcu_back u_back (
      .clock(clock),
      .reset(reset),
      .q_empty(q_empty),
      .q_data(q_data),
      .q_pop(q_pop),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_data(rsp_data)
   );

endmodule

// ----- rtl/core/tcu_checker.sv -----
`include "token_classifier_unit_assert.svh"

module tcu_checker import tcu_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_full,
   input logic rsp_empty,
   input logic rsp_pop,
   input rsp_type rsp_data
);

   logic rsp_wait;
   logic end_shown, end_ok;
   logic delim_shown;

   assign rsp_wait = !rsp_empty && !rsp_pop;
   assign end_shown = !rsp_empty && rsp_data.token_class == ClsEnd;
   assign end_ok = rsp_data.token_length == 8'd0 && rsp_data.last;
   assign delim_shown = !rsp_empty && rsp_data.token_class == ClsDelim;

   `TCU_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_wait, !rsp_empty && $stable(rsp_data))
   `TCU_ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, rsp_empty && !req_full)
   `TCU_ASSERT_IMPLY(a_end_token, clock, reset, end_shown, end_ok)
   `TCU_ASSERT_IMPLY(a_delim_len, clock, reset, delim_shown, rsp_data.token_length == 8'd1)

endmodule

bind token_classifier_unit tcu_checker u_checker (
   .clock(clock),
   .reset(reset),
   .req_full(req_full),
   .rsp_empty(rsp_empty),
   .rsp_pop(rsp_pop),
   .rsp_data(rsp_data)
);
